// ----- rtl/pnsgt_pkg.sv -----
// Package: table sizing, state machine type and status codes of the sequence gap tracker.
package pnsgt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int VENDOR_W  = 16;
  localparam int NODE_W    = 8;
  localparam int SEQ_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int MISSING_W = 15;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0]   REG_EXPECTED_VENDOR = 1'b0;
  localparam logic [VENDOR_W-1:0] VENDOR_RESET        = 16'hFFFF;

  localparam logic [STATUS_W-1:0] STAT_WRONG_VENDOR = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_TABLE_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FIRST        = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_IN_ORDER     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_GAP          = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE    = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_LATE         = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ----- rtl/pnsgt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pnsgt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/per_node_sequence_gap_tracker.sv -----
// Top level of the per-node sequence gap tracker.
//
// Each accepted packet header (vendor id, node id, 16-bit sequence) yields one
// result: a status code, a duplicate flag and, on a gap, the count of skipped
// sequence numbers. Node ids are held in a register table of TABLE_DEPTH
// entries that is compared in parallel in the cycle the header is taken; the
// last sequence of each node lives in a synchronous RAM that is read in that
// same cycle and written back in the next, or later while an earlier result
// still waits at the output. Headers are taken only in the idle state. The
// result sits in an output register, so one pending result does not hold
// back the next header. The expected vendor id is written through
// the APB-style port at byte address 0 and resets to 0xFFFF.
module per_node_sequence_gap_tracker
  import pnsgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VENDOR_W-1:0]   in_vendor_id,
  input  logic [NODE_W-1:0]     in_node_id,
  input  logic [SEQ_W-1:0]      in_seq,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_is_duplicate,
  output logic [MISSING_W-1:0]  out_missing_count,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  state_t state_r, state_nxt;

  logic [VENDOR_W-1:0] expected_vendor_r;
  logic [NODE_W-1:0]   node_ids_r [TABLE_DEPTH];
  logic [CNT_W-1:0]    entry_count_r;

  logic                vendor_ok_r;
  logic                hit_r;
  logic [IDX_W-1:0]    slot_r;
  logic [NODE_W-1:0]   node_r;
  logic [SEQ_W-1:0]    seq_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_dup_r;
  logic [MISSING_W-1:0] out_missing_r;

  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic [IDX_W-1:0]       slot;

  logic                   in_xfer;
  logic                   exec_done;
  logic                   cfg_wr;

  logic [IDX_W-1:0]       ram_raddr;
  logic [IDX_W-1:0]       ram_waddr;
  logic                   ram_we;
  logic [SEQ_W-1:0]       ram_rdata;

  logic [SEQ_W-1:0]       diff;
  logic                   table_full;
  logic                   append;
  logic [STATUS_W-1:0]    res_status;
  logic                   res_dup;
  logic [MISSING_W-1:0]   res_missing;

  // Parallel compare against the live entries.
  always_comb begin
    slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < entry_count_r) && (node_ids_r[i] == in_node_id);
      if (match[i]) begin
        slot = slot | IDX_W'(i);
      end
    end
    hit = |match;
  end

  assign in_xfer   = in_valid && in_ready;
  assign exec_done = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    ram_raddr = slot_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = slot;
      end
      ST_EXEC: begin
        in_ready  = 1'b0;
        ram_raddr = slot_r;
      end
      default: begin
        in_ready  = 1'b0;
        ram_raddr = slot_r;
      end
    endcase
  end

  // Classify against the stored sequence.
  always_comb begin
    diff        = seq_r - ram_rdata;
    table_full  = (entry_count_r >= CNT_W'(TABLE_DEPTH));
    append      = vendor_ok_r && !hit_r && !table_full;
    ram_we      = 1'b0;
    res_dup     = 1'b0;
    res_missing = '0;
    if (!vendor_ok_r) begin
      res_status = STAT_WRONG_VENDOR;
    end else if (!hit_r) begin
      if (table_full) begin
        res_status = STAT_TABLE_FULL;
      end else begin
        res_status = STAT_FIRST;
        ram_we     = exec_done;
      end
    end else if (diff == '0) begin
      res_status = STAT_DUPLICATE;
      res_dup    = 1'b1;
    end else if (diff[SEQ_W-1]) begin
      res_status = STAT_LATE;
    end else if (diff == SEQ_W'(1)) begin
      res_status = STAT_IN_ORDER;
      ram_we     = exec_done;
    end else begin
      res_status  = STAT_GAP;
      res_missing = MISSING_W'(diff - SEQ_W'(1));
      ram_we      = exec_done;
    end
    ram_waddr = hit_r ? slot_r : entry_count_r[IDX_W-1:0];
  end

  pnsgt_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (seq_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      expected_vendor_r <= VENDOR_RESET;
      entry_count_r     <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_EXPECTED_VENDOR)) begin
        expected_vendor_r <= cfg_pwdata[VENDOR_W-1:0];
      end
      if (exec_done && append) begin
        entry_count_r <= entry_count_r + CNT_W'(1);
      end
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the header and lookup result; load results and append entries.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vendor_ok_r <= (in_vendor_id == expected_vendor_r);
      hit_r       <= hit;
      slot_r      <= slot;
      node_r      <= in_node_id;
      seq_r       <= in_seq;
    end
    if (exec_done) begin
      out_status_r  <= res_status;
      out_dup_r     <= res_dup;
      out_missing_r <= res_missing;
    end
    if (exec_done && append) begin
      node_ids_r[entry_count_r[IDX_W-1:0]] <= node_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_duplicate  = out_dup_r;
  assign out_missing_count = out_missing_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_EXPECTED_VENDOR)
                      ? CFG_DW'(expected_vendor_r) : '0;

endmodule

// ----- verif/gap_tracker_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sequence gap tracker: mirrors its table and register and compares results.
module gap_tracker_checker
  import pnsgt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [VENDOR_W-1:0]  in_vendor_id,
  input  logic [NODE_W-1:0]    in_node_id,
  input  logic [SEQ_W-1:0]     in_seq,

  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic                 out_is_duplicate,
  input  logic [MISSING_W-1:0] out_missing_count,

  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [CFG_DW-1:0]    cfg_pwdata,
  input  logic [CFG_DW-1:0]    cfg_prdata,
  input  logic                 cfg_pready,

  output int                   mismatch_count,
  output int                   results_owed,
  output logic [STAT_LATE:0]   status_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 dup;
    logic [MISSING_W-1:0] missing;
  } verdict_t;

  logic [VENDOR_W-1:0] vendor_mirror;
  logic [NODE_W-1:0]   node_tab     [TABLE_DEPTH];
  logic [SEQ_W-1:0]    last_seq_tab [TABLE_DEPTH];
  int                  node_count;
  verdict_t            owed_q [$];
  int                  fails;
  logic [STAT_LATE:0]  seen;

  function automatic verdict_t track_packet(input logic [VENDOR_W-1:0] vendor,
                                            input logic [NODE_W-1:0]   node,
                                            input logic [SEQ_W-1:0]    seq);
    verdict_t   v;
    int         slot;
    logic [SEQ_W-1:0] diff;
    v.status  = STAT_WRONG_VENDOR;
    v.dup     = 1'b0;
    v.missing = '0;
    if (vendor != vendor_mirror) return v;
    slot = -1;
    for (int i = 0; i < node_count; i++) begin
      if (slot < 0 && node_tab[i] == node) slot = i;
    end
    if (slot < 0) begin
      if (node_count >= TABLE_DEPTH) begin
        v.status = STAT_TABLE_FULL;
      end else begin
        node_tab[node_count]     = node;
        last_seq_tab[node_count] = seq;
        node_count++;
        v.status = STAT_FIRST;
      end
      return v;
    end
    diff = seq - last_seq_tab[slot];
    if (diff == '0) begin
      v.status = STAT_DUPLICATE;
      v.dup    = 1'b1;
    end else if (diff[SEQ_W-1]) begin
      v.status = STAT_LATE;
    end else begin
      last_seq_tab[slot] = seq;
      if (diff == SEQ_W'(1)) begin
        v.status = STAT_IN_ORDER;
      end else begin
        v.status  = STAT_GAP;
        v.missing = MISSING_W'(diff - SEQ_W'(1));
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      vendor_mirror = VENDOR_RESET;
      node_count    = 0;
      owed_q.delete();
      fails         = 0;
      seen          = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_EXPECTED_VENDOR) begin
        if (cfg_pwrite) begin
          vendor_mirror = cfg_pwdata[VENDOR_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(vendor_mirror)) begin
          fails++;
          $error("expected_vendor_id readback mismatch: expected %0h, got %0h",
                 CFG_DW'(vendor_mirror), cfg_prdata);
        end
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          fails++;
          $error("result transfer with nothing expected: status %0d", out_status);
        end else begin
          want = owed_q.pop_front();
          if (out_status !== want.status) begin
            fails++;
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          end
          if (out_is_duplicate !== want.dup) begin
            fails++;
            $error("is_duplicate mismatch: expected %0d, got %0d", want.dup,
                   out_is_duplicate);
          end
          if (out_missing_count !== want.missing) begin
            fails++;
            $error("missing_count mismatch: expected %0d, got %0d", want.missing,
                   out_missing_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = track_packet(in_vendor_id, in_node_id, in_seq);
        owed_q.push_back(want);
        seen[want.status] = 1'b1;
      end
    end
    mismatch_count <= fails;
    results_owed   <= owed_q.size();
    status_seen    <= seen;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives packet headers and register writes into the gap tracker and reports.
module tb;
  import pnsgt_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int NODE_SPAN   = 1 << NODE_W;
  localparam logic [CFG_AW-1:0] VENDOR_ADDR = {REG_EXPECTED_VENDOR, 2'b00};
  localparam logic [CFG_AW-1:0] SPARE_ADDR  = {~REG_EXPECTED_VENDOR, 2'b00};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VENDOR_W-1:0]  in_vendor_id = '0;
  logic [NODE_W-1:0]    in_node_id = '0;
  logic [SEQ_W-1:0]     in_seq = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_is_duplicate;
  logic [MISSING_W-1:0] out_missing_count;

  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr = '0;
  logic [CFG_DW-1:0]    cfg_pwdata = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  int                   mismatch_count;
  int                   results_owed;
  logic [STAT_LATE:0]   status_seen;

  int                   idle_cycles;
  int                   results_seen;
  int                   headers_sent;
  int                   burst_left;
  logic [VENDOR_W-1:0]  cur_vendor;
  logic [SEQ_W-1:0]     sent_seq  [NODE_SPAN];
  bit                   node_used [NODE_SPAN];
  int                   node_pool [$];

  per_node_sequence_gap_tracker dut (.*);
  gap_tracker_checker chk (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles  <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int hi_len;
    int lo_len;
    bit held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hi_len = $urandom_range(1, 16);
      lo_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (hi_len) @(posedge clk);
      if (!held && results_seen >= 100) begin
        held   = 1'b1;
        lo_len = 300;
      end
      if (lo_len > 0) begin
        out_ready <= 1'b0;
        repeat (lo_len) @(posedge clk);
      end
    end
  end

  task automatic apb_access(input logic write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_vendor(input logic [VENDOR_W-1:0] vendor);
    apb_access(1'b1, SPARE_ADDR, $urandom);
    apb_access(1'b1, VENDOR_ADDR, {16'($urandom), vendor});
    apb_access(1'b0, VENDOR_ADDR, '0);
    cur_vendor = vendor;
  endtask

  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic offer(input logic [VENDOR_W-1:0] vendor, input logic [NODE_W-1:0] node,
                       input logic [SEQ_W-1:0] seq);
    int gap;
    logic [SEQ_W-1:0] step;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_vendor_id <= vendor;
    in_node_id   <= node;
    in_seq       <= seq;
    do @(posedge clk); while (!in_ready);
    headers_sent++;
    if (vendor == cur_vendor) begin
      if (!node_used[node]) begin
        node_used[node] = 1'b1;
        node_pool.push_back(node);
        sent_seq[node] = seq;
      end else begin
        step = seq - sent_seq[node];
        if (step != '0 && !step[SEQ_W-1]) sent_seq[node] = seq;
      end
    end
  endtask

  task automatic pick_packet(output logic [VENDOR_W-1:0] vendor,
                             output logic [NODE_W-1:0] node,
                             output logic [SEQ_W-1:0] seq);
    int roll;
    int step;
    roll   = $urandom_range(0, 99);
    vendor = cur_vendor;
    node   = NODE_W'($urandom);
    seq    = SEQ_W'($urandom);
    if (roll < 8) begin
      vendor = cur_vendor ^ VENDOR_W'($urandom_range(1, (1 << VENDOR_W) - 1));
    end else begin
      if (node_pool.size() != 0 && $urandom_range(0, 3) != 0)
        node = NODE_W'(node_pool[$urandom_range(0, node_pool.size() - 1)]);
      if (!node_used[node]) begin
        if ($urandom_range(0, 3) == 0) seq = 16'hFFF0 | SEQ_W'($urandom_range(0, 15));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60)      step = 1;
        else if (roll < 72) step = $urandom_range(2, 40);
        else if (roll < 76) step = $urandom_range(41, 32766);
        else if (roll < 78) step = 32767;
        else if (roll < 86) step = 0;
        else if (roll < 94) step = -$urandom_range(1, 50);
        else if (roll < 97) step = -$urandom_range(51, 32767);
        else                step = 32768;
        seq = sent_seq[node] + SEQ_W'(step);
      end
    end
  endtask

  task automatic run_random(input int count);
    logic [VENDOR_W-1:0] vendor;
    logic [NODE_W-1:0]   node;
    logic [SEQ_W-1:0]    seq;
    repeat (count) begin
      pick_packet(vendor, node, seq);
      offer(vendor, node, seq);
    end
  endtask

  initial begin
    headers_sent = 0;
    burst_left   = 0;
    cur_vendor   = VENDOR_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, VENDOR_ADDR, '0);
    set_vendor(16'hFFFF);

    offer(~cur_vendor, 8'h00, 16'h0000);
    offer(cur_vendor, 8'h00, 16'hFFFF);
    offer(cur_vendor, 8'h00, 16'h0000);
    offer(cur_vendor, 8'h00, 16'h0000);
    offer(cur_vendor, 8'h00, 16'hFFFF);
    offer(cur_vendor, 8'h00, 16'h8000);
    offer(cur_vendor, 8'h00, 16'h7FFF);
    offer(cur_vendor, 8'hFF, 16'h0000);
    offer(cur_vendor, 8'hFF, 16'h0002);
    offer(cur_vendor, 8'hFF, 16'h0003);
    offer(cur_vendor ^ 16'h0001, 8'hFF, 16'h0004);
    offer(cur_vendor, 8'hAA, 16'h5555);
    offer(cur_vendor, 8'h55, 16'hAAAA);
    drain();

    set_vendor(16'h0000);
    run_random(180);
    drain();

    set_vendor(VENDOR_W'($urandom_range(1, (1 << VENDOR_W) - 2)));
    run_random(180);
    drain();

    set_vendor(16'hFFFF);
    run_random(190);
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d packet headers over four vendor id settings; %0d results checked.",
             headers_sent, results_seen);
    $display("Status codes produced (bit n set for code n): %b", status_seen);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
